### hw/rtl/efba_pkg.sv
package efba_pkg;

  localparam int ADDR_W = 12;
  localparam int STATUS_W = 3;

  localparam int ARENA_BYTES = 2048;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_RECORDS_DEF = 64;

  // bump pointer reaches ARENA_BYTES at most
  localparam int OFF_W = $clog2(ARENA_BYTES + 1);
  // bump + header + largest request
  localparam int SUM_W = $clog2(ARENA_BYTES + HEADER_BYTES + (1 << ADDR_W));

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_ARENA_FULL  = 3'd1,
    ST_TABLE_FULL  = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_UNKNOWN     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              is_free;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] start;
  } record_t;

  typedef struct packed {
    cmd_t              command;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] block_address;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_address;
    status_t           status;
  } result_t;

endpackage

### hw/rtl/exact_fit_block_allocator_unit.sv
// channel | dir | tdata, lowest bit up                      | tuser
// s_axis  | in  | request_bytes[11:0], block_address[23:12] | command[0]
// m_axis  | out | payload_address[11:0]                     | status[2:0]
//
// one request at a time, N = records in the table (up to MAX_RECORDS)
// no match: the scan reads all N records before the result, none with an empty table
// a match at record k ends the one-read-per-cycle scan early
// the result waits in an output register so the next request is taken while
// the master side stalls; a second result then holds off the slave side
// rst clears record count and bump pointer; the record memory needs no clear
module exact_fit_block_allocator_unit
  import efba_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,  // request_bytes, block_address
  input  logic                s_tuser,  // command
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,  // payload_address
  output logic [STATUS_W-1:0] m_tuser   // status
);

  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  request_t         in_req;
  result_t          res;
  logic             res_valid;
  logic             res_ready;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  record_t          mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  record_t          mem_wr_data;
  result_t          out_res;

  assign in_req.command = cmd_t'(s_tuser);
  assign in_req.request_bytes = s_tdata[11:0];
  assign in_req.block_address = s_tdata[23:12];

  efba_ctrl #(
    .MAX_RECORDS(MAX_RECORDS),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_req(in_req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .mem_rd_en(mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .mem_wr_en(mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data)
  );

  efba_rec_mem #(
    .DEPTH(MAX_RECORDS),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk(clk),
    .rd_en(mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en(mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  // output register frees the controller once the result is parked
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'b0000, out_res.payload_address};
  assign m_tuser = out_res.status;

endmodule

### hw/rtl/efba_rec_mem.sv
module efba_rec_mem
  import efba_pkg::*;
#(
  parameter int DEPTH = MAX_RECORDS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output record_t          rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  record_t          wr_data
);

  record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/efba_ctrl.sv
module efba_ctrl
  import efba_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int IDX_W = $clog2(MAX_RECORDS),
  parameter int CNT_W = $clog2(MAX_RECORDS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  request_t         in_req,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res,
  output logic             mem_rd_en,
  output logic [IDX_W-1:0] mem_rd_addr,
  input  record_t          mem_rd_data,
  output logic             mem_wr_en,
  output logic [IDX_W-1:0] mem_wr_addr,
  output record_t          mem_wr_data
);

  state_t           state, state_next;
  request_t         cur, cur_next;
  logic [CNT_W-1:0] rec_count, rec_count_next;
  logic [OFF_W-1:0] bump, bump_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic             chk_valid, chk_valid_next;
  logic [IDX_W-1:0] chk_idx, chk_idx_next;
  result_t          res_next;

  logic              issue;
  logic              hit;
  logic [SUM_W-1:0]  need;
  logic [ADDR_W-1:0] new_start;

  assign issue = (state == S_SCAN) && (rd_idx < rec_count);
  assign hit = chk_valid &&
               ((cur.command == CMD_ALLOC) ?
                (mem_rd_data.is_free && (mem_rd_data.length == cur.request_bytes)) :
                (mem_rd_data.start == cur.block_address));
  assign need = SUM_W'(bump) + SUM_W'(HEADER_BYTES) + SUM_W'(cur.request_bytes);
  assign new_start = ADDR_W'(bump) + ADDR_W'(HEADER_BYTES);

  assign mem_rd_en = issue;
  assign mem_rd_addr = rd_idx[IDX_W-1:0];
  assign in_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    cur_next = cur;
    rec_count_next = rec_count;
    bump_next = bump;
    rd_idx_next = rd_idx;
    chk_valid_next = 1'b0;
    chk_idx_next = rd_idx[IDX_W-1:0];
    res_next = res;
    mem_wr_en = 1'b0;
    mem_wr_addr = chk_idx;
    mem_wr_data = mem_rd_data;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cur_next = in_req;
          rd_idx_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_next = rd_idx + CNT_W'(1);
          chk_valid_next = 1'b1;
        end
        if (hit) begin
          chk_valid_next = 1'b0;
          state_next = S_DONE;
          if (cur.command == CMD_ALLOC) begin
            mem_wr_en = 1'b1;
            mem_wr_data.is_free = 1'b0;
            res_next = '{payload_address: mem_rd_data.start, status: ST_OK};
          end else if (mem_rd_data.is_free) begin
            res_next = '{payload_address: '0, status: ST_DOUBLE_FREE};
          end else begin
            mem_wr_en = 1'b1;
            mem_wr_data.is_free = 1'b1;
            res_next = '{payload_address: '0, status: ST_OK};
          end
        end else if (!chk_valid && !issue) begin
          // scan ran past the last record without a match
          state_next = S_DONE;
          if (cur.command == CMD_FREE) begin
            res_next = '{payload_address: '0, status: ST_UNKNOWN};
          end else if (rec_count == CNT_W'(MAX_RECORDS)) begin
            res_next = '{payload_address: '0, status: ST_TABLE_FULL};
          end else if (need > SUM_W'(ARENA_BYTES)) begin
            res_next = '{payload_address: '0, status: ST_ARENA_FULL};
          end else begin
            mem_wr_en = 1'b1;
            mem_wr_addr = rec_count[IDX_W-1:0];
            mem_wr_data = '{is_free: 1'b0, length: cur.request_bytes, start: new_start};
            res_next = '{payload_address: new_start, status: ST_OK};
            bump_next = OFF_W'(need);
            rec_count_next = rec_count + CNT_W'(1);
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rec_count <= '0;
      bump <= '0;
      chk_valid <= 1'b0;
    end else begin
      state <= state_next;
      rec_count <= rec_count_next;
      bump <= bump_next;
      chk_valid <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    rd_idx <= rd_idx_next;
    chk_idx <= chk_idx_next;
    res <= res_next;
  end

  a_wr_in_scan: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> state == S_SCAN)
    else $error("record write outside of scan");

  a_wr_ends_scan: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |=> state == S_DONE)
    else $error("scan did not finish after record write");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rec_count <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond table size");

  a_bump_bound: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(bump) <= SUM_W'(ARENA_BYTES))
    else $error("bump pointer beyond arena");

  a_alloc_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == ST_ARENA_FULL || res.status == ST_TABLE_FULL))
      |-> cur.command == CMD_ALLOC)
    else $error("allocation status on a free command");

endmodule
